FILE: hdl/gppc_pkg.sv
// Shared types, codes and reset values of the gait phase / pump pressure controller.
// Used by the channel interfaces, the register file, the step logic and the top level.
package gppc_pkg;

  typedef enum logic [1:0] {
    MODE_NO_CONTROL = 2'd0,
    MODE_CONTROL    = 2'd1,
    MODE_RESET      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_STANCE1 = 2'd0,
    PH_STANCE2 = 2'd1,
    PH_PUSH    = 2'd2,
    PH_PULL    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_STANCE1 = 3'd1,
    ACT_STANCE2 = 3'd2,
    ACT_PUSH    = 3'd3,
    ACT_PULL    = 3'd4,
    ACT_HOME    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CMD_LEAVE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MID_TO_LATE   = 3'd0,
    REG_LATE_TO_PUSH  = 3'd1,
    REG_PUSH_TO_PULL  = 3'd2,
    REG_PULL_TO_STNC  = 3'd3,
    REG_EARLY_RETURN  = 3'd4,
    REG_FOOT_CONTACT  = 3'd5,
    REG_PRESS_TARGET  = 3'd6,
    REG_PRESS_BAND    = 3'd7
  } reg_idx_t;

  typedef logic signed [15:0] angle_t;
  typedef logic [11:0]        load_t;
  typedef logic signed [15:0] press_t;
  typedef logic [14:0]        band_t;

  localparam angle_t RST_EARLY_RETURN = -16'sd350;
  localparam load_t  RST_FOOT_CONTACT = 12'd500;
  localparam band_t  RST_PRESS_BAND   = 15'd500;

  typedef struct packed {
    angle_t mid_to_late_stance_angle;
    angle_t late_stance_to_push_angle;
    angle_t push_to_pull_angle;
    angle_t pull_to_stance_angle;
    angle_t early_return_angle;
    load_t  foot_contact_level;
    press_t pressure_target;
    band_t  pressure_band;
  } cfg_t;

  typedef struct packed {
    logic [1:0] control_mode;
    angle_t     ankle_angle;
    load_t      foot_load;
    press_t     line_pressure;
  } item_t;

  typedef struct packed {
    phase_t  phase;
    action_t phase_action;
    cmd_t    motor_command;
    logic    motor_on;
    logic    clear_valve_setpoints;
  } result_t;

endpackage

FILE: hdl/gppc_if.sv
// Valid/ready channel interfaces for tick items and result items.
// Depends on gppc_pkg for field types.
interface gppc_in_if
  import gppc_pkg::*;
;
  logic   valid;
  logic   ready;
  logic [1:0] control_mode;
  angle_t ankle_angle;
  load_t  foot_load;
  press_t line_pressure;

  modport source(output valid, control_mode, ankle_angle, foot_load, line_pressure,
                 input ready);
  modport sink(input valid, control_mode, ankle_angle, foot_load, line_pressure,
               output ready);
endinterface

interface gppc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase;
  logic [2:0] phase_action;
  logic [1:0] motor_command;
  logic       motor_on;
  logic       clear_valve_setpoints;

  modport source(output valid, phase, phase_action, motor_command, motor_on,
                 clear_valve_setpoints, input ready);
  modport sink(input valid, phase, phase_action, motor_command, motor_on,
               clear_valve_setpoints, output ready);
endinterface

FILE: hdl/gppc_cfg_regs.sv
// Configuration register file: thresholds, contact level and pump set point.
// Depends on gppc_pkg for the register index codes and reset values.
module gppc_cfg_regs
  import gppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        we,
  input  logic [2:0]  idx,
  input  logic [15:0] wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (reg_idx_t'(idx))
        REG_MID_TO_LATE:  cfg_nxt.mid_to_late_stance_angle  = wdata;
        REG_LATE_TO_PUSH: cfg_nxt.late_stance_to_push_angle = wdata;
        REG_PUSH_TO_PULL: cfg_nxt.push_to_pull_angle        = wdata;
        REG_PULL_TO_STNC: cfg_nxt.pull_to_stance_angle      = wdata;
        REG_EARLY_RETURN: cfg_nxt.early_return_angle        = wdata;
        REG_FOOT_CONTACT: cfg_nxt.foot_contact_level        = wdata[11:0];
        REG_PRESS_TARGET: cfg_nxt.pressure_target           = wdata;
        REG_PRESS_BAND:   cfg_nxt.pressure_band             = wdata[14:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_to_late_stance_angle  <= '0;
      cfg_r.late_stance_to_push_angle <= '0;
      cfg_r.push_to_pull_angle        <= '0;
      cfg_r.pull_to_stance_angle      <= '0;
      cfg_r.early_return_angle        <= RST_EARLY_RETURN;
      cfg_r.foot_contact_level        <= RST_FOOT_CONTACT;
      cfg_r.pressure_target           <= '0;
      cfg_r.pressure_band             <= RST_PRESS_BAND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/gppc_step.sv
// Per-tick decision logic: gait phase step, phase action and pump hysteresis.
// Depends on gppc_pkg; purely combinational, state is held by the caller.
module gppc_step
  import gppc_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  input  phase_t  phase_cur,
  input  logic    pump_cur,
  output phase_t  phase_nxt,
  output logic    pump_nxt,
  output result_t res
);

  logic signed [17:0] press_x;
  logic signed [17:0] lo_bound;
  logic signed [17:0] hi_bound;
  logic               contact;
  phase_t             ph_step;

  // Bounds at full precision: 16-bit target plus or minus 15-bit band.
  assign press_x  = {{2{item.line_pressure[15]}}, item.line_pressure};
  assign lo_bound = {{2{cfg.pressure_target[15]}}, cfg.pressure_target}
                    - $signed({3'b000, cfg.pressure_band});
  assign hi_bound = {{2{cfg.pressure_target[15]}}, cfg.pressure_target}
                    + $signed({3'b000, cfg.pressure_band});
  assign contact  = item.foot_load >= cfg.foot_contact_level;

  // Advance at most one phase per tick.
  always_comb begin
    ph_step = phase_cur;
    case (phase_cur)
      PH_STANCE1: if (item.ankle_angle <= cfg.mid_to_late_stance_angle) ph_step = PH_STANCE2;
      PH_STANCE2: if (item.ankle_angle >= cfg.late_stance_to_push_angle) ph_step = PH_PUSH;
      PH_PUSH:    if (item.ankle_angle <= cfg.push_to_pull_angle) ph_step = PH_PULL;
      PH_PULL: begin
        if (item.ankle_angle >= cfg.pull_to_stance_angle ||
            (item.ankle_angle >= cfg.early_return_angle && contact))
          ph_step = PH_STANCE1;
      end
      default:    ph_step = phase_cur;
    endcase
  end

  always_comb begin
    phase_nxt                 = phase_cur;
    pump_nxt                  = 1'b0;
    res.phase_action          = ACT_NONE;
    res.motor_command         = CMD_STOP;
    res.clear_valve_setpoints = 1'b0;
    case (mode_t'(item.control_mode))
      MODE_NO_CONTROL: begin
        phase_nxt = phase_cur;
      end
      MODE_CONTROL: begin
        phase_nxt = ph_step;
        case (ph_step)
          PH_STANCE1: res.phase_action = ACT_STANCE1;
          PH_STANCE2: res.phase_action = ACT_STANCE2;
          PH_PUSH:    res.phase_action = ACT_PUSH;
          PH_PULL:    res.phase_action = ACT_PULL;
          default:    res.phase_action = ACT_NONE;
        endcase
        res.clear_valve_setpoints = (ph_step == PH_PULL);
        if (press_x < lo_bound && press_x > 18'sd0) begin
          res.motor_command = CMD_RUN;
          pump_nxt          = 1'b1;
        end else if (press_x > hi_bound) begin
          res.motor_command = CMD_STOP;
          pump_nxt          = 1'b0;
        end else begin
          res.motor_command = CMD_LEAVE;
          pump_nxt          = pump_cur;
        end
      end
      default: begin
        // Reset mode, and the unused mode code: home and restart the cycle.
        phase_nxt        = PH_STANCE1;
        res.phase_action = ACT_HOME;
      end
    endcase
    res.phase    = phase_nxt;
    res.motor_on = pump_nxt;
  end

endmodule

FILE: hdl/gait_phase_pressure_controller.sv
// Top level of the gait phase / pump pressure controller.
// Depends on gppc_pkg, gppc_if, gppc_cfg_regs and gppc_step.
//
// Usage:
//   in_if   carries one control tick per beat: control_mode, ankle_angle,
//           foot_load, line_pressure. A beat moves when valid and ready are high.
//   out_if  returns exactly one result beat per tick, in order: phase,
//           phase_action, motor_command, motor_on, clear_valve_setpoints.
//   cfg_*   write port for the eight threshold/set point registers; write
//           only while no tick is in flight.
// Pipeline: a tick is registered in the input stage, then its result in the
//   result stage, which drives out_if.
// Throughput: one tick per cycle while out_if.ready stays high. The gait phase
//   and pump state feed back into the next tick's decision through a single
//   register stage, which allows that rate.
// Reset (rst_n low, synchronous): both stages empty, gait phase back to first
//   stance, pump marked stopped, registers at their reset values.
// Stall: when out_if.ready is low the result beat holds; one more tick can
//   wait in the input stage, then in_if.ready drops until the result moves.
module gait_phase_pressure_controller
  import gppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gppc_in_if.sink     in_if,
  gppc_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   in_item;

  // Input stage
  logic    s1_valid_r;
  item_t   s1_item_r;
  // Controller state
  phase_t  phase_r;
  phase_t  phase_nxt;
  logic    pump_r;
  logic    pump_nxt;
  // Result stage
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;

  logic    in_take;
  logic    s1_go;

  gppc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  assign in_item.control_mode  = in_if.control_mode;
  assign in_item.ankle_angle   = in_if.ankle_angle;
  assign in_item.foot_load     = in_if.foot_load;
  assign in_item.line_pressure = in_if.line_pressure;

  // Advance the input stage when the result slot is free or being drained.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_take     = in_if.valid && in_if.ready;

  gppc_step u_step (
    .item      (s1_item_r),
    .cfg       (cfg),
    .phase_cur (phase_r),
    .pump_cur  (pump_r),
    .phase_nxt (phase_nxt),
    .pump_nxt  (pump_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_STANCE1;
      pump_r      <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        // Commit the state only when the tick's result is captured.
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        pump_r      <= pump_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid                 = out_valid_r;
  assign out_if.phase                 = out_res_r.phase;
  assign out_if.phase_action          = out_res_r.phase_action;
  assign out_if.motor_command         = out_res_r.motor_command;
  assign out_if.motor_on              = out_res_r.motor_on;
  assign out_if.clear_valve_setpoints = out_res_r.clear_valve_setpoints;

endmodule

FILE: tb/gppc_checker.sv
// Scoreboard for the gait phase / pump pressure controller: watches both channels
// and the register write port, predicts every result beat and compares it.
// Depends on gppc_pkg and the channel interfaces in gppc_if.
module gppc_checker
  import gppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gppc_in_if          in_ch,
  gppc_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output int          outstanding,
  output int          mismatches
);

  int      limit [8];
  phase_t  gait_ph;
  logic    pump_on;
  result_t expected_q [$];
  int      fails;

  initial begin
    outstanding = 0;
    mismatches  = 0;
    fails       = 0;
  end

  // Advance the gait machine and the pump state by one tick.
  function automatic result_t next_result(input logic [1:0] mode, input int ang,
                                          input int foot, input int prs);
    result_t r;
    r.phase_action          = ACT_NONE;
    r.motor_command         = CMD_STOP;
    r.clear_valve_setpoints = 1'b0;
    case (mode)
      MODE_NO_CONTROL: pump_on = 1'b0;
      MODE_CONTROL: begin
        case (gait_ph)
          PH_STANCE1: if (ang <= limit[REG_MID_TO_LATE]) gait_ph = PH_STANCE2;
          PH_STANCE2: if (ang >= limit[REG_LATE_TO_PUSH]) gait_ph = PH_PUSH;
          PH_PUSH:    if (ang <= limit[REG_PUSH_TO_PULL]) gait_ph = PH_PULL;
          default: begin
            if (ang >= limit[REG_PULL_TO_STNC] ||
                (ang >= limit[REG_EARLY_RETURN] && foot >= limit[REG_FOOT_CONTACT]))
              gait_ph = PH_STANCE1;
          end
        endcase
        case (gait_ph)
          PH_STANCE1: r.phase_action = ACT_STANCE1;
          PH_STANCE2: r.phase_action = ACT_STANCE2;
          PH_PUSH:    r.phase_action = ACT_PUSH;
          default:    r.phase_action = ACT_PULL;
        endcase
        r.clear_valve_setpoints = (gait_ph == PH_PULL);
        if (prs < limit[REG_PRESS_TARGET] - limit[REG_PRESS_BAND] && prs > 0) begin
          r.motor_command = CMD_RUN;
          pump_on = 1'b1;
        end else if (prs > limit[REG_PRESS_TARGET] + limit[REG_PRESS_BAND]) begin
          r.motor_command = CMD_STOP;
          pump_on = 1'b0;
        end else begin
          r.motor_command = CMD_LEAVE;
        end
      end
      default: begin
        // reset mode and the unused mode code both home the leg
        pump_on = 1'b0;
        gait_ph = PH_STANCE1;
        r.phase_action = ACT_HOME;
      end
    endcase
    r.phase     = gait_ph;
    r.motor_on  = pump_on;
    return r;
  endfunction

  function automatic int field_miss(input string name, input logic [2:0] want,
                                    input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      limit[REG_MID_TO_LATE]  = 0;
      limit[REG_LATE_TO_PUSH] = 0;
      limit[REG_PUSH_TO_PULL] = 0;
      limit[REG_PULL_TO_STNC] = 0;
      limit[REG_EARLY_RETURN] = int'(RST_EARLY_RETURN);
      limit[REG_FOOT_CONTACT] = int'(RST_FOOT_CONTACT);
      limit[REG_PRESS_TARGET] = 0;
      limit[REG_PRESS_BAND]   = int'(RST_PRESS_BAND);
      gait_ph = PH_STANCE1;
      pump_on = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_FOOT_CONTACT: limit[REG_FOOT_CONTACT] = int'(cfg_wdata[11:0]);
          REG_PRESS_BAND:   limit[REG_PRESS_BAND]   = int'(cfg_wdata[14:0]);
          default:          limit[cfg_idx]          = int'($signed(cfg_wdata));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, phase %0d action %0d",
                   $time, out_ch.phase, out_ch.phase_action);
          fails++;
        end else begin
          want = expected_q.pop_front();
          fails += field_miss("phase", 3'(want.phase), 3'(out_ch.phase));
          fails += field_miss("phase_action", 3'(want.phase_action),
                              3'(out_ch.phase_action));
          fails += field_miss("motor_command", 3'(want.motor_command),
                              3'(out_ch.motor_command));
          fails += field_miss("motor_on", 3'(want.motor_on), 3'(out_ch.motor_on));
          fails += field_miss("clear_valve_setpoints", 3'(want.clear_valve_setpoints),
                              3'(out_ch.clear_valve_setpoints));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(next_result(in_ch.control_mode,
                                         int'($signed(in_ch.ankle_angle)),
                                         int'(in_ch.foot_load),
                                         int'($signed(in_ch.line_pressure))));
    end
    outstanding <= expected_q.size();
    mismatches  <= fails;
  end

endmodule

FILE: tb/tb_top.sv
// Top of the gait phase / pump pressure controller testbench: clock, reset,
// register programming, tick stimulus and receiver stalls, plus the verdict.
// Depends on gppc_pkg, gppc_if, gppc_checker and the controller RTL.
module tb_top
  import gppc_pkg::*;
;

  // mode code the block has no name for; it must behave like reset mode
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int          pending;
  int          fail_cnt;

  // register values as the block sees them, used to aim stimulus at thresholds
  int cfg_now [8];

  // receiver stall pattern state
  int rdy_style;
  int rdy_left;
  int rdy_period;

  gppc_in_if  in_if();
  gppc_out_if out_if();

  gait_phase_pressure_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  gppc_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .outstanding (pending),
    .mismatches  (fail_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold every input at a known value from time zero.
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.control_mode  = MODE_NO_CONTROL;
    in_if.ankle_angle   = '0;
    in_if.foot_load     = '0;
    in_if.line_pressure = '0;
    out_if.ready        = 1'b0;
    rdy_style           = 0;
    rdy_left            = 0;
    rdy_period          = 1;
  end

  // Receiver: pick a new stall style whenever the style's countdown runs out. Style 0
  // never stalls, 1 and 2 stall at random (lightly, heavily), 3 toggles ready
  // on a fixed period so stalls line up with bursts in a regular way.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_style  = $urandom_range(0, 3);
      rdy_left   = $urandom_range(32, 256);
      rdy_period = $urandom_range(1, 12);
    end else begin
      rdy_left--;
    end
    case (rdy_style)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= ($urandom_range(0, 9) < 7);
      2:       out_if.ready <= ($urandom_range(0, 9) < 3);
      default: out_if.ready <= ((rdy_left / rdy_period) % 2 == 0);
    endcase
  end

  // Build one tick from plain integers; fields keep only their own bits.
  function automatic item_t tick(input logic [1:0] mode, input int ang, input int foot,
                                 input int prs);
    item_t t;
    t.control_mode  = mode;
    t.ankle_angle   = angle_t'(ang);
    t.foot_load     = load_t'(foot);
    t.line_pressure = press_t'(prs);
    return t;
  endfunction

  // Random tick: mostly control mode so the gait machine walks its full cycle,
  // with angles, loads and pressures clustered on the live thresholds.
  function automatic item_t make_tick();
    int         r;
    int         d;
    logic [1:0] mode;
    int         ang;
    int         foot;
    int         prs;
    r = $urandom_range(0, 99);
    if (r < 84)      mode = MODE_CONTROL;
    else if (r < 90) mode = MODE_NO_CONTROL;
    else if (r < 96) mode = MODE_RESET;
    else             mode = MODE_UNDEF;

    r = $urandom_range(0, 99);
    d = $urandom_range(0, 6);
    d = d - 3;
    if (r < 35) begin
      ang = cfg_now[$urandom_range(REG_MID_TO_LATE, REG_EARLY_RETURN)] + d;
    end else if (r < 50) begin
      d = $urandom_range(0, 600);
      ang = cfg_now[$urandom_range(REG_MID_TO_LATE, REG_EARLY_RETURN)] + d - 300;
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: ang = -18000;
        1: ang = 18000;
        2: ang = -32768;
        default: ang = 32767;
      endcase
    end else if (r < 90) begin
      d = $urandom_range(0, 36000);
      ang = d - 18000;
    end else begin
      ang = $urandom_range(0, 65535);
    end

    r = $urandom_range(0, 99);
    d = $urandom_range(0, 4);
    if (r < 50)      foot = cfg_now[REG_FOOT_CONTACT] + d - 2;
    else if (r < 70) foot = ($urandom_range(0, 1) != 0) ? 4095 : 0;
    else             foot = $urandom_range(0, 4095);

    r = $urandom_range(0, 99);
    d = $urandom_range(0, 4);
    d = d - 2;
    if (r < 18)      prs = cfg_now[REG_PRESS_TARGET] - cfg_now[REG_PRESS_BAND] + d;
    else if (r < 36) prs = cfg_now[REG_PRESS_TARGET] + cfg_now[REG_PRESS_BAND] + d;
    else if (r < 46) prs = d + 1;
    else if (r < 56) prs = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    else if (r < 76) prs = $urandom_range(1, 1 + 2 * cfg_now[REG_PRESS_BAND])
                           + cfg_now[REG_PRESS_TARGET] - cfg_now[REG_PRESS_BAND] - 1;
    else             prs = $urandom_range(0, 65535);
    return tick(mode, ang, foot, prs);
  endfunction

  // Present one beat and hold it until the block takes it. Valid stays high on
  // return so the next beat of a burst can follow without a bubble.
  task automatic send_tick(input item_t t);
    in_if.valid         <= 1'b1;
    in_if.control_mode  <= t.control_mode;
    in_if.ankle_angle   <= t.ankle_angle;
    in_if.foot_load     <= t.foot_load;
    in_if.line_pressure <= t.line_pressure;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and wait until every expected result beat has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register write per cycle; the caller drops the write enable afterwards.
  task automatic write_reg(input reg_idx_t idx, input int v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v[15:0];
    case (idx)
      REG_FOOT_CONTACT: cfg_now[idx] = int'(v[11:0]);
      REG_PRESS_BAND:   cfg_now[idx] = int'(v[14:0]);
      default:          cfg_now[idx] = int'($signed(v[15:0]));
    endcase
    @(posedge clk);
  endtask

  // Program all eight registers for one phase of the run.
  task automatic program_set(input int kind);
    int vals [8];
    case (kind)
      1: begin
        // low corner of every register
        foreach (vals[i]) vals[i] = -18000;
        vals[REG_FOOT_CONTACT] = 0;
        vals[REG_PRESS_TARGET] = -32768;
        vals[REG_PRESS_BAND]   = 0;
      end
      2: begin
        // high corner of every register
        foreach (vals[i]) vals[i] = 18000;
        vals[REG_FOOT_CONTACT] = 3000;
        vals[REG_PRESS_TARGET] = 32767;
        vals[REG_PRESS_BAND]   = 32767;
      end
      3: begin
        // raw bit patterns past the documented ranges
        vals[REG_MID_TO_LATE]  = 32767;
        vals[REG_LATE_TO_PUSH] = -32768;
        vals[REG_PUSH_TO_PULL] = 32767;
        vals[REG_PULL_TO_STNC] = -32768;
        vals[REG_EARLY_RETURN] = 32767;
        vals[REG_FOOT_CONTACT] = 4095;
        vals[REG_PRESS_TARGET] = 32767;
        vals[REG_PRESS_BAND]   = 32767;
      end
      4: begin
        // full random words, upper bits of the narrow registers included
        foreach (vals[i]) vals[i] = $urandom_range(0, 65535);
      end
      default: begin
        foreach (vals[i]) vals[i] = $urandom_range(0, 36000) - 18000;
        vals[REG_EARLY_RETURN] = $urandom_range(0, 2000) - 1000;
        vals[REG_FOOT_CONTACT] = $urandom_range(0, 3000);
        vals[REG_PRESS_TARGET] = $urandom_range(0, 8000);
        vals[REG_PRESS_BAND]   = $urandom_range(0, 2000);
      end
    endcase
    foreach (vals[i]) write_reg(reg_idx_t'(i), vals[i]);
    cfg_we <= 1'b0;
  endtask

  // Random ticks in bursts; gaps of random length between bursts unless the
  // phase runs back to back.
  task automatic run_ticks(input int count, input bit with_gaps);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        send_tick(make_tick());
        burst--;
        left--;
      end
      if (with_gaps && left > 0) begin
        gap = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 19) == 0) gap = 20;
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    cfg_now[REG_MID_TO_LATE]  = 0;
    cfg_now[REG_LATE_TO_PUSH] = 0;
    cfg_now[REG_PUSH_TO_PULL] = 0;
    cfg_now[REG_PULL_TO_STNC] = 0;
    cfg_now[REG_EARLY_RETURN] = -350;
    cfg_now[REG_FOOT_CONTACT] = 500;
    cfg_now[REG_PRESS_TARGET] = 0;
    cfg_now[REG_PRESS_BAND]   = 500;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk on reset values: no-control mode, each threshold hit exactly
    // and missed by one, early pull exit on angle and load, homing from both
    // reset codes, extreme field values.
    send_tick(tick(MODE_NO_CONTROL, 0, 0, 600));
    send_tick(tick(MODE_CONTROL, 1, 0, 500));
    send_tick(tick(MODE_CONTROL, 0, 0, 501));
    send_tick(tick(MODE_CONTROL, -1, 0, -500));
    send_tick(tick(MODE_CONTROL, 0, 0, -32768));
    send_tick(tick(MODE_CONTROL, 1, 4095, 32767));
    send_tick(tick(MODE_CONTROL, 0, 0, 0));
    send_tick(tick(MODE_CONTROL, -351, 4095, 0));
    send_tick(tick(MODE_CONTROL, -350, 499, 0));
    send_tick(tick(MODE_CONTROL, -350, 500, 0));
    send_tick(tick(MODE_CONTROL, -32768, 0, 0));
    send_tick(tick(MODE_CONTROL, 32767, 0, 0));
    send_tick(tick(MODE_CONTROL, -32768, 0, 0));
    send_tick(tick(MODE_CONTROL, -1, 0, 0));
    send_tick(tick(MODE_CONTROL, 0, 0, 0));
    send_tick(tick(MODE_RESET, 32767, 4095, -1));
    send_tick(tick(MODE_UNDEF, -1, 4095, 32767));
    send_tick(tick(MODE_CONTROL, -18000, 3000, 0));
    send_tick(tick(MODE_RESET, 18000, 0, 32767));

    // Raise the set point so the run branch of the hysteresis is reachable,
    // then walk the band edges and the positive-pressure guard.
    drain();
    write_reg(REG_PRESS_TARGET, 2000);
    write_reg(REG_PRESS_BAND, 500);
    cfg_we <= 1'b0;
    send_tick(tick(MODE_CONTROL, 100, 0, 1));
    send_tick(tick(MODE_CONTROL, 100, 0, 0));
    send_tick(tick(MODE_CONTROL, 100, 0, 1499));
    send_tick(tick(MODE_CONTROL, 100, 0, 1500));
    send_tick(tick(MODE_CONTROL, 100, 0, 2500));
    send_tick(tick(MODE_CONTROL, 100, 0, 2501));
    send_tick(tick(MODE_CONTROL, 100, 0, 1));
    send_tick(tick(MODE_NO_CONTROL, 100, 0, 1));

    // Random phases, each on its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      program_set(ph);
      run_ticks(215, ph != 5);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
